[hdl/flptw_pkg.sv]
// Shared types, codes and the control store for the page-table walker.
// No dependencies; every other file refers to this package by scoped names.
package flptw_pkg;

    // input actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TRANS = 2'd1;
    localparam logic [1:0] ACT_SETF  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTPRES = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // page kinds
    localparam logic [1:0] KIND_4K = 2'd0;
    localparam logic [1:0] KIND_2M = 2'd1;
    localparam logic [1:0] KIND_1G = 2'd2;

    // walk levels (level 4 table is index 3)
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    localparam int VA_W    = 48;
    localparam int PA_W    = 53;
    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 14;
    localparam int ROOT_W  = 5;
    localparam int FRAME_W = 40;   // entry bits 51:12

    typedef logic [3:0] t_upc;

    // microcode steps
    localparam t_upc UPC_WAIT  = 4'd0;
    localparam t_upc UPC_DISP  = 4'd1;
    localparam t_upc UPC_WRITE = 4'd2;   // dispatch base: UPC_WRITE + action
    localparam t_upc UPC_TRANS = 4'd3;
    localparam t_upc UPC_SETF  = 4'd4;
    localparam t_upc UPC_NOP   = 4'd5;
    localparam t_upc UPC_READ  = 4'd6;
    localparam t_upc UPC_EVAL  = 4'd7;
    localparam t_upc UPC_POST  = 4'd8;
    localparam t_upc UPC_CLEAR = 4'd9;

    // jump conditions
    localparam logic [2:0] COND_NEXT    = 3'd0;
    localparam logic [2:0] COND_GOTO    = 3'd1;
    localparam logic [2:0] COND_ACCEPT  = 3'd2;
    localparam logic [2:0] COND_ACTION  = 3'd3;
    localparam logic [2:0] COND_FAULT   = 3'd4;
    localparam logic [2:0] COND_WALK    = 3'd5;
    localparam logic [2:0] COND_OUTFREE = 3'd6;
    localparam logic [2:0] COND_CLEAR   = 3'd7;

    typedef struct packed {
        logic take_in;
        logic mem_rd;
        logic eval;
        logic wr_word;
        logic clr;
        logic post;
    } t_ctrl;

    typedef struct packed {
        t_ctrl      ctrl;
        logic [2:0] cond;
        t_upc       target;
    } t_uword;

    typedef struct packed {
        logic       accept;
        logic       frame_bad;
        logic       cont;
        logic       clr_last;
        logic       out_free;
        logic [1:0] act;
    } t_sstat;

    localparam t_ctrl C_NONE  = '{default: 1'b0};
    localparam t_ctrl C_TAKE  = '{take_in: 1'b1, default: 1'b0};
    localparam t_ctrl C_READ  = '{mem_rd: 1'b1, default: 1'b0};
    localparam t_ctrl C_EVAL  = '{eval: 1'b1, default: 1'b0};
    localparam t_ctrl C_WRITE = '{wr_word: 1'b1, default: 1'b0};
    localparam t_ctrl C_CLR   = '{clr: 1'b1, default: 1'b0};
    localparam t_ctrl C_POST  = '{post: 1'b1, default: 1'b0};

    // control store
    function automatic t_uword uword(input t_upc upc);
        t_uword w;
        w = '{ctrl: C_NONE, cond: COND_GOTO, target: UPC_WAIT};
        unique case (upc)
            UPC_WAIT:  w = '{ctrl: C_TAKE,  cond: COND_ACCEPT,  target: UPC_DISP};
            UPC_DISP:  w = '{ctrl: C_NONE,  cond: COND_ACTION,  target: UPC_WRITE};
            UPC_WRITE: w = '{ctrl: C_WRITE, cond: COND_GOTO,    target: UPC_POST};
            UPC_TRANS: w = '{ctrl: C_NONE,  cond: COND_GOTO,    target: UPC_READ};
            UPC_SETF:  w = '{ctrl: C_NONE,  cond: COND_GOTO,    target: UPC_READ};
            UPC_NOP:   w = '{ctrl: C_NONE,  cond: COND_GOTO,    target: UPC_POST};
            UPC_READ:  w = '{ctrl: C_READ,  cond: COND_FAULT,   target: UPC_POST};
            UPC_EVAL:  w = '{ctrl: C_EVAL,  cond: COND_WALK,    target: UPC_READ};
            UPC_POST:  w = '{ctrl: C_POST,  cond: COND_OUTFREE, target: UPC_WAIT};
            UPC_CLEAR: w = '{ctrl: C_CLR,   cond: COND_CLEAR,   target: UPC_WAIT};
            default:   w = '{ctrl: C_NONE,  cond: COND_GOTO,    target: UPC_WAIT};
        endcase
        return w;
    endfunction

endpackage

[hdl/four_level_page_table_walker.sv]
// Four-level page-table walker: top level with config register and result register.
// Depends on flptw_pkg, flptw_useq and flptw_dpath.

// A local table memory of TABLE_PAGES frames of 512 64-bit words is walked from
// root_frame, x86-64 style, with 1G and 2M large pages honoured. After reset the
// block runs a clearing pass over all TABLE_PAGES*512 words (16384 at the default),
// one word a cycle, and takes no transfer until it is done; config writes are
// taken throughout. A small microcode program steps a single-port datapath, and
// the table memory, with one access per cycle, sets the pace: a table write or
// an unused action goes through a dispatch step, its own step and the post step,
// and a walk goes through a dispatch step and its own step, then one read step and
// one evaluate step per table level read, then the post step; a frame outside the
// table memory ends the walk in its read step. Set-flags writes the leaf back in
// its evaluate step at no extra cost. The next input transfer is taken as soon as
// the result is in the output register, whether or not it has been taken yet.
module four_level_page_table_walker #(
    parameter int TABLE_PAGES = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: root_frame
    input  logic          i_cfg_we,
    input  logic [4:0]    i_cfg_wdata,
    // input items
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [47:0] virt_addr, [111:48] new_flags, [125:112] word_index,
    // [189:126] word_data, [191:190] zero
    input  logic [191:0]  s_axis_tdata,
    // [1:0] action
    input  logic [1:0]    s_axis_tuser,
    // results
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [52:0] phys_addr, [55:53] zero
    output logic [55:0]   m_axis_tdata,
    // [1:0] page_kind, [3:2] status
    output logic [3:0]    m_axis_tuser
);

    logic [flptw_pkg::ROOT_W-1:0] r_root;
    logic                         r_out_valid;
    logic [flptw_pkg::PA_W-1:0]   r_out_phys;
    logic [1:0]                   r_out_kind;
    logic [1:0]                   r_out_status;

    flptw_pkg::t_ctrl             w_ctrl;
    flptw_pkg::t_sstat            w_stat;
    logic                         w_out_free;
    logic [flptw_pkg::PA_W-1:0]   w_phys;
    logic [1:0]                   w_kind;
    logic [1:0]                   w_status;

    // root frame register, written any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root <= '0;
        end else if (i_cfg_we) begin
            r_root <= i_cfg_wdata;
        end
    end

    // output register frees when empty or being taken this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;

    flptw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    flptw_dpath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_virt_addr  (s_axis_tdata[47:0]),
        .i_new_flags  (s_axis_tdata[111:48]),
        .i_word_index (s_axis_tdata[125:112]),
        .i_word_data  (s_axis_tdata[189:126]),
        .i_root_frame (r_root),
        .i_out_free   (w_out_free),
        .o_stat       (w_stat),
        .o_phys_addr  (w_phys),
        .o_page_kind  (w_kind),
        .o_status     (w_status)
    );

    // result register: loaded by the post step once it is free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.post && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.post && w_out_free) begin
            r_out_phys   <= w_phys;
            r_out_kind   <= w_kind;
            r_out_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_phys};
    assign m_axis_tuser  = {r_out_status, r_out_kind};

endmodule

[hdl/flptw_useq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on flptw_pkg.
module flptw_useq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flptw_pkg::t_sstat  i_stat,
    output flptw_pkg::t_ctrl   o_ctrl
);

    flptw_pkg::t_upc   r_upc;
    flptw_pkg::t_upc   n_upc;
    flptw_pkg::t_uword w_word;

    assign w_word = flptw_pkg::uword(r_upc);
    assign o_ctrl = w_word.ctrl;

    always_comb begin
        unique case (w_word.cond)
            flptw_pkg::COND_NEXT:    n_upc = r_upc + 1'b1;
            flptw_pkg::COND_GOTO:    n_upc = w_word.target;
            flptw_pkg::COND_ACCEPT:  n_upc = i_stat.accept ? w_word.target : r_upc;
            flptw_pkg::COND_ACTION:  n_upc = w_word.target + {2'b00, i_stat.act};
            flptw_pkg::COND_FAULT:   n_upc = i_stat.frame_bad ? w_word.target : r_upc + 1'b1;
            flptw_pkg::COND_WALK:    n_upc = i_stat.cont ? w_word.target : flptw_pkg::UPC_POST;
            flptw_pkg::COND_OUTFREE: n_upc = i_stat.out_free ? w_word.target : r_upc;
            flptw_pkg::COND_CLEAR:   n_upc = i_stat.clr_last ? w_word.target : r_upc;
            default:                 n_upc = flptw_pkg::UPC_WAIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= flptw_pkg::UPC_CLEAR;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[hdl/flptw_dpath.sv]
// Walk datapath: item registers, table memory with clear counter, entry evaluation.
// Depends on flptw_pkg; driven by the control word from flptw_useq.
module flptw_dpath #(
    parameter int TABLE_PAGES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  flptw_pkg::t_ctrl                  i_ctrl,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic [flptw_pkg::VA_W-1:0]        i_virt_addr,
    input  logic [flptw_pkg::WORD_W-1:0]      i_new_flags,
    input  logic [flptw_pkg::WIDX_W-1:0]      i_word_index,
    input  logic [flptw_pkg::WORD_W-1:0]      i_word_data,
    input  logic [flptw_pkg::ROOT_W-1:0]      i_root_frame,
    input  logic                              i_out_free,
    output flptw_pkg::t_sstat                 o_stat,
    output logic [flptw_pkg::PA_W-1:0]        o_phys_addr,
    output logic [1:0]                        o_page_kind,
    output logic [1:0]                        o_status
);

    localparam int FW    = $clog2(TABLE_PAGES);
    localparam int AW    = FW + 9;
    localparam int DEPTH = TABLE_PAGES * 512;

    logic [flptw_pkg::WORD_W-1:0] mem [DEPTH];

    logic [1:0]                      r_act;
    logic [flptw_pkg::VA_W-1:0]      r_va;
    logic [flptw_pkg::WORD_W-1:0]    r_data;   // word_data or new_flags
    logic [flptw_pkg::WIDX_W-1:0]    r_widx;
    logic [flptw_pkg::FRAME_W-1:0]   r_frame;
    logic [1:0]                      r_lvl;
    logic [AW-1:0]                   r_addr;
    logic [flptw_pkg::WORD_W-1:0]    r_rdata;
    logic [AW-1:0]                   r_clr;
    logic [flptw_pkg::PA_W-1:0]      r_res_phys;
    logic [1:0]                      r_res_kind;
    logic [1:0]                      r_res_status;

    logic                            w_accept;
    logic                            w_frame_bad;
    logic [8:0]                      w_idx;
    logic [AW-1:0]                   w_raddr;
    logic                            w_rd;
    logic                            w_present;
    logic                            w_large;
    logic                            w_wb;
    logic                            w_we;
    logic [AW-1:0]                   w_waddr;
    logic [flptw_pkg::WORD_W-1:0]    w_wdata;
    logic [flptw_pkg::WORD_W-1:0]    w_leaf;
    logic                            w_widx_ok;

    assign o_in_ready = i_ctrl.take_in;
    assign w_accept   = i_in_valid && i_ctrl.take_in;

    assign w_frame_bad = r_frame >= flptw_pkg::FRAME_W'(TABLE_PAGES);

    always_comb begin
        unique case (r_lvl)
            flptw_pkg::LVL_PML4: w_idx = r_va[47:39];
            flptw_pkg::LVL_PDPT: w_idx = r_va[38:30];
            flptw_pkg::LVL_PD:   w_idx = r_va[29:21];
            default:             w_idx = r_va[20:12];
        endcase
    end

    assign w_raddr = {r_frame[FW-1:0], w_idx};
    assign w_rd    = i_ctrl.mem_rd && !w_frame_bad;

    assign w_present = r_rdata[0];
    assign w_large   = r_rdata[7] && (r_lvl == flptw_pkg::LVL_PDPT || r_lvl == flptw_pkg::LVL_PD);
    assign w_leaf    = {12'd0, r_rdata[51:12], 12'd0} | r_data;
    assign w_wb      = i_ctrl.eval && w_present && !w_large && r_lvl == flptw_pkg::LVL_PT
                       && r_act == flptw_pkg::ACT_SETF;
    assign w_widx_ok = {18'd0, r_widx} < 32'(DEPTH);

    // write port: clearing pass, table word write, leaf write-back
    always_comb begin
        priority if (i_ctrl.clr) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (i_ctrl.wr_word) begin
            w_we    = w_widx_ok;
            w_waddr = AW'(r_widx);
            w_wdata = r_data;
        end else begin
            w_we    = w_wb;
            w_waddr = r_addr;
            w_wdata = w_leaf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_rd) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctrl.clr) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act        <= i_action;
            r_va         <= i_virt_addr;
            r_data       <= (i_action == flptw_pkg::ACT_WRITE) ? i_word_data : i_new_flags;
            r_widx       <= i_word_index;
            r_frame      <= flptw_pkg::FRAME_W'(i_root_frame);
            r_lvl        <= flptw_pkg::LVL_PML4;
            r_res_phys   <= '0;
            r_res_kind   <= flptw_pkg::KIND_4K;
            r_res_status <= flptw_pkg::ST_OK;
        end else if (i_ctrl.mem_rd) begin
            if (w_frame_bad) begin
                r_res_status <= flptw_pkg::ST_RANGE;
            end else begin
                r_addr <= w_raddr;
            end
        end else if (i_ctrl.eval) begin
            if (!w_present) begin
                r_res_status <= flptw_pkg::ST_NOTPRES;
            end else if (w_large) begin
                r_res_kind <= (r_lvl == flptw_pkg::LVL_PDPT) ? flptw_pkg::KIND_1G
                                                             : flptw_pkg::KIND_2M;
                if (r_act == flptw_pkg::ACT_SETF) begin
                    r_res_status <= flptw_pkg::ST_REFUSED;
                end else if (r_lvl == flptw_pkg::LVL_PDPT) begin
                    r_res_phys <= {1'b0, r_rdata[51:30], r_va[29:0]};
                end else begin
                    r_res_phys <= {1'b0, r_rdata[51:21], r_va[20:0]};
                end
            end else if (r_lvl == flptw_pkg::LVL_PT) begin
                r_res_phys <= {1'b0, r_rdata[51:12], r_va[11:0]};
            end else begin
                r_frame <= r_rdata[51:12];
                r_lvl   <= r_lvl - 1'b1;
            end
        end
    end

    assign o_stat = '{
        accept:    w_accept,
        frame_bad: w_frame_bad,
        cont:      w_present && !w_large && r_lvl != flptw_pkg::LVL_PT,
        clr_last:  r_clr == AW'(DEPTH - 1),
        out_free:  i_out_free,
        act:       r_act
    };

    assign o_phys_addr = r_res_phys;
    assign o_page_kind = r_res_kind;
    assign o_status    = r_res_status;

endmodule

[test/four_level_page_table_walker_tb.sv]
// Self-checking testbench for four_level_page_table_walker: builds page tables, then
// translates and rewrites leaves across several root frames, checking every result.
// Depends on flptw_pkg and four_level_page_table_walker; nothing else.
module four_level_page_table_walker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_PAGES = 32;
    localparam int TOTAL_WORDS = TABLE_PAGES * 512;
    // Clearing pass plus about 1850 transfers at their slowest:
    // sender gap, full walk and a long receiver stall each.
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int PHASE_ITEMS = 370;

    // one request as carried on the input stream
    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] virt_addr;
        logic [63:0] new_flags;
        logic [13:0] word_index;
        logic [63:0] word_data;
    } t_walk_item;

    // one result as carried on the output stream
    typedef struct packed {
        logic [52:0] phys_addr;
        logic [1:0]  page_kind;
        logic [1:0]  status;
    } t_walk_result;

    // Mirror of the table memory and root register; every accepted request
    // is walked here and its result queued, oldest first.
    class walk_checker;
        logic [63:0]  tbl [TOTAL_WORDS];
        logic [4:0]   root;
        t_walk_result expected_walks[$];
        int           errors;
        int           checked;

        function new();
            foreach (tbl[i]) tbl[i] = '0;
            root    = '0;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_root(input logic [4:0] value);
            root = value;
        endfunction

        function int pending();
            return expected_walks.size();
        endfunction

        function void note_request(input t_walk_item it);
            t_walk_result r;
            logic [39:0]  frame;
            logic [13:0]  addr;
            logic [63:0]  e;
            bit           done;
            r = '0;
            if (it.action == flptw_pkg::ACT_WRITE) begin
                // 14-bit index always lands inside the 32-frame store
                tbl[it.word_index] = it.word_data;
            end else if (it.action == flptw_pkg::ACT_TRANS ||
                         it.action == flptw_pkg::ACT_SETF) begin
                frame = {35'd0, root};
                done  = 1'b0;
                for (int lvl = 3; lvl >= 0 && !done; lvl--) begin
                    if (frame >= TABLE_PAGES) begin
                        r.status = flptw_pkg::ST_RANGE;
                        done = 1'b1;
                    end else begin
                        addr = {frame[4:0], it.virt_addr[12 + 9 * lvl +: 9]};
                        e    = tbl[addr];
                        if (!e[0]) begin
                            r.status = flptw_pkg::ST_NOTPRES;
                            done = 1'b1;
                        end else if ((lvl == 2 || lvl == 1) && e[7]) begin
                            // large page: PS only counts in PDPT and PD entries
                            r.page_kind = (lvl == 2) ? flptw_pkg::KIND_1G
                                                     : flptw_pkg::KIND_2M;
                            if (it.action == flptw_pkg::ACT_SETF)
                                r.status = flptw_pkg::ST_REFUSED;
                            else if (lvl == 2)
                                r.phys_addr = {1'b0, e[51:30], it.virt_addr[29:0]};
                            else
                                r.phys_addr = {1'b0, e[51:21], it.virt_addr[20:0]};
                            done = 1'b1;
                        end else if (lvl == 0) begin
                            if (it.action == flptw_pkg::ACT_SETF)
                                tbl[addr] = {12'd0, e[51:12], 12'd0} | it.new_flags;
                            r.phys_addr = {1'b0, e[51:12], it.virt_addr[11:0]};
                            done = 1'b1;
                        end else begin
                            frame = e[51:12];
                        end
                    end
                end
            end
            expected_walks.push_back(r);
        endfunction

        function void check_response(input t_walk_result got);
            t_walk_result exp;
            checked++;
            if (expected_walks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d unexpected: phys %h kind %0d status %0d",
                             checked, got.phys_addr, got.page_kind, got.status);
                return;
            end
            exp = expected_walks.pop_front();
            if (got.phys_addr !== exp.phys_addr || got.page_kind !== exp.page_kind ||
                got.status !== exp.status) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d: exp phys %h kind %0d status %0d",
                             checked, exp.phys_addr, exp.page_kind, exp.status);
                    $display("    got phys %h kind %0d status %0d",
                             got.phys_addr, got.page_kind, got.status);
                end
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_we = 1'b0;
    logic [4:0]    i_cfg_wdata = '0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [191:0]  s_axis_tdata = '0;    // virt_addr, new_flags, word_index, word_data, zero
    logic [1:0]    s_axis_tuser = '0;    // action
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [55:0]   m_axis_tdata;         // phys_addr, zero
    logic [3:0]    m_axis_tuser;         // page_kind, status

    walk_checker   board;
    logic [47:0]   mapped_vas[$];        // addresses with a freshly built walk
    int            burst_left = 0;
    int            sent_items = 0;
    logic [15:0]   rx_cycle = '0;
    int unsigned   cycle_count = 0;

    four_level_page_table_walker #(
        .TABLE_PAGES (TABLE_PAGES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("four_level_page_table_walker_tb: done, errors");
            $finish;
        end
    end

    // Result side: take transfers and check them; tready follows a rotating
    // pattern - always ready, random, long square-wave stalls, random with one stalled slot in eight.
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_response('{phys_addr: m_axis_tdata[52:0],
                                   page_kind: m_axis_tuser[1:0],
                                   status:    m_axis_tuser[3:2]});
        case (rx_cycle[8:7])
            2'd0: begin
                m_axis_tready <= 1'b1;
            end
            2'd1: begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd2: begin
                m_axis_tready <= rx_cycle[4];
            end
            default: begin
                m_axis_tready <= (rx_cycle[2:0] != 3'd5) && ($urandom_range(0, 1) != 0);
            end
        endcase
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] va_of(input logic [8:0] i4, input logic [8:0] i3,
                                          input logic [8:0] i2, input logic [8:0] i1,
                                          input logic [11:0] offs);
        return {i4, i3, i2, i1, offs};
    endfunction

    // Present entry naming a frame (or large-page base), other bits random.
    function automatic logic [63:0] pte(input logic [39:0] frame, input logic ps);
        logic [63:0] w;
        w = rand64();
        w[51:12] = frame;
        w[0] = 1'b1;
        w[7] = ps;
        return w;
    endfunction

    // Frame number at or above the table memory size.
    function automatic logic [39:0] far_frame();
        logic [63:0] f;
        f = rand64();
        if ($urandom_range(0, 1) != 0)
            f[39:5] = 35'd1 << $urandom_range(0, 3);
        else if (f[39:5] == 0)
            f[5] = 1'b1;
        return f[39:0];
    endfunction

    // Input side: bursts of back-to-back transfers separated by random gaps.
    // tvalid is only lowered at the start of a gap or in drain, never around a transfer.
    task automatic send(input logic [1:0] act, input logic [47:0] va,
                        input logic [63:0] flags, input logic [13:0] widx,
                        input logic [63:0] wdata);
        t_walk_item it;
        int gap;
        it = '{action: act, virt_addr: va, new_flags: flags,
               word_index: widx, word_data: wdata};
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.word_data, it.word_index, it.new_flags, it.virt_addr};
        s_axis_tuser  <= it.action;
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_request(it);
        sent_items++;
    endtask

    task automatic put_word(input logic [4:0] frame, input logic [8:0] entry,
                            input logic [63:0] data);
        send(flptw_pkg::ACT_WRITE, 48'(rand64()), rand64(), {frame, entry}, data);
    endtask

    // Hold off the input until every outstanding result has been taken.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [4:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        board.set_root(value);
        i_cfg_we    <= 1'b0;
    endtask

    // Writes a walk for a random address from the current root: mostly a 4K
    // chain, some 1G/2M leaves, a few chains cut by a frame beyond the store.
    task automatic build_walk();
        logic [47:0] va;
        logic [63:0] big;
        logic [4:0]  f3, f2, f1;
        int          shape;
        int          cut;
        va    = 48'(rand64());
        f3    = 5'($urandom_range(0, 31));
        f2    = 5'($urandom_range(0, 31));
        f1    = 5'($urandom_range(0, 31));
        shape = $urandom_range(0, 15);
        cut   = (shape == 0) ? $urandom_range(1, 3) : 0;
        big   = rand64();
        // PML4: PS is meaningless here, so it is left random
        put_word(board.root, va[47:39],
                 pte((cut == 3) ? far_frame() : {35'd0, f3}, 1'($urandom_range(0, 1))));
        if (cut != 3) begin
            if (shape >= 1 && shape <= 3) begin
                put_word(f3, va[38:30], pte(big[39:0], 1'b1));
            end else begin
                put_word(f3, va[38:30], pte((cut == 2) ? far_frame() : {35'd0, f2}, 1'b0));
                if (cut != 2) begin
                    if (shape >= 4 && shape <= 6) begin
                        put_word(f2, va[29:21], pte(big[39:0], 1'b1));
                    end else begin
                        put_word(f2, va[29:21],
                                 pte((cut == 1) ? far_frame() : {35'd0, f1}, 1'b0));
                        if (cut != 1)
                            put_word(f1, va[20:12],
                                     pte(big[39:0], 1'($urandom_range(0, 1))));
                    end
                end
            end
        end
        mapped_vas.push_back(va);
        if (mapped_vas.size() > 64)
            void'(mapped_vas.pop_front());
    endtask

    // One random step: mostly walks over built tables, some new builds, the rest noise.
    task automatic random_step();
        logic [47:0] va;
        logic [63:0] flags;
        int          pick;
        pick = $urandom_range(0, 99);
        if (mapped_vas.size() != 0) begin
            va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
            va[11:0] = 12'($urandom);
            if ($urandom_range(0, 3) == 0)
                va[29:12] = 18'($urandom);
        end else begin
            va = 48'(rand64());
        end
        flags = rand64();
        if (pick < 22) begin
            build_walk();
        end else if (pick < 65) begin
            send(flptw_pkg::ACT_TRANS, va, rand64(), 14'($urandom_range(0, 16383)),
                 rand64());
        end else if (pick < 80) begin
            // mostly keep the leaf present so later walks still get through
            if ($urandom_range(0, 4) != 0)
                flags[0] = 1'b1;
            send(flptw_pkg::ACT_SETF, va, flags, 14'($urandom_range(0, 16383)), rand64());
        end else if (pick < 88) begin
            send(flptw_pkg::ACT_WRITE, 48'(rand64()), rand64(),
                 14'($urandom_range(0, 16383)), rand64());
        end else if (pick < 96) begin
            send(($urandom_range(0, 1) != 0) ? flptw_pkg::ACT_TRANS : flptw_pkg::ACT_SETF,
                 48'(rand64()), flags, 14'($urandom_range(0, 16383)), rand64());
        end else begin
            send(flptw_pkg::ACT_NONE, 48'(rand64()), rand64(),
                 14'($urandom_range(0, 16383)), rand64());
        end
    endtask

    initial begin : stimulus
        logic [47:0] va;
        logic [4:0]  next_root;
        int          goal;
        board = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_root(5'd0);

        // ---- directed part (the first transfer waits out the clearing pass) ----
        // empty store: nothing present at level 4
        send(flptw_pkg::ACT_TRANS, 48'd0, 64'd0, 14'd0, 64'd0);
        send(flptw_pkg::ACT_NONE, '1, '1, '1, '1);
        // 4K chain with PS set at level 4 (ignored) and the widest leaf base
        put_word(5'd0, 9'h1FF, {12'hFFF, 40'd1, 12'hFFF});
        put_word(5'd1, 9'h000, {12'h000, 40'd2, 12'h001});
        put_word(5'd2, 9'h155, {12'hABC, 40'd3, 12'h07F});
        put_word(5'd3, 9'h0AA, {12'hFFF, {40{1'b1}}, 12'hFFF});
        va = va_of(9'h1FF, 9'h000, 9'h155, 9'h0AA, 12'hFFF);
        send(flptw_pkg::ACT_TRANS, va, rand64(), '1, rand64());
        // flags of zero drop the present bit of the leaf
        send(flptw_pkg::ACT_SETF, va, 64'd0, '0, rand64());
        send(flptw_pkg::ACT_TRANS, va, rand64(), '0, rand64());
        send(flptw_pkg::ACT_SETF, va, '1, '1, rand64());
        // 2M page whose PAT bit sits inside the offset range
        put_word(5'd2, 9'h156, {12'h5A5, 40'hABCDE_12345, 12'h081});
        va = va_of(9'h1FF, 9'h000, 9'h156, 9'h1C3, 12'h777);
        send(flptw_pkg::ACT_TRANS, va, rand64(), '0, rand64());
        send(flptw_pkg::ACT_SETF, va, '1, '0, rand64());
        // 1G page with the widest base
        put_word(5'd1, 9'h001, {12'h000, {40{1'b1}}, 12'h0FF});
        va = va_of(9'h1FF, 9'h001, 9'h1FF, 9'h1FF, 12'hFFF);
        send(flptw_pkg::ACT_TRANS, va, rand64(), '1, rand64());
        send(flptw_pkg::ACT_SETF, va, rand64(), '1, rand64());
        // table pointers just past and far past the store
        put_word(5'd0, 9'h005, {12'h000, 40'd32, 12'h001});
        send(flptw_pkg::ACT_TRANS, va_of(9'h005, 9'h0, 9'h0, 9'h0, 12'h0), rand64(), '0,
             rand64());
        put_word(5'd1, 9'h002, {12'hFFF, {40{1'b1}}, 12'h001});
        send(flptw_pkg::ACT_SETF, va_of(9'h1FF, 9'h002, 9'h0, 9'h0, 12'h0), rand64(), '0,
             rand64());
        // missing level 3 entry
        send(flptw_pkg::ACT_TRANS, va_of(9'h1FF, 9'h003, 9'h0, 9'h0, 12'h0), rand64(), '0,
             rand64());
        // extremes of the word index
        send(flptw_pkg::ACT_WRITE, 48'(rand64()), rand64(), 14'h3FFF, '1);
        send(flptw_pkg::ACT_WRITE, 48'(rand64()), rand64(), 14'h0000, 64'd0);
        send(flptw_pkg::ACT_TRANS, '1, '1, '1, '1);

        // ---- random phases, one root frame each; root only changes when idle ----
        for (int p = 0; p < 5; p++) begin
            drain();
            case (p)
                0: begin
                    next_root = 5'd31;
                end
                2: begin
                    next_root = 5'd0;
                end
                default: begin
                    next_root = 5'($urandom_range(1, 30));
                end
            endcase
            write_root(next_root);
            mapped_vas.delete();
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal)
                random_step();
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("four_level_page_table_walker_tb: done, clean");
        else
            $display("four_level_page_table_walker_tb: done, errors");
        $finish;
    end

endmodule
